/* hdl/ialu_pkg.sv */
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared widths, opcodes and types for the integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

    // datapath width and the split used by the multiplier
    localparam int DW  = 64;
    localparam int HW  = DW / 2;
    localparam int LW  = DW - HW;
    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    // opcodes
    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_IDENT = 5'd1;
    localparam logic [4:0] OP_SUB   = 5'd2;
    localparam logic [4:0] OP_NEG   = 5'd3;
    localparam logic [4:0] OP_MUL   = 5'd4;
    localparam logic [4:0] OP_DIV   = 5'd5;
    localparam logic [4:0] OP_MOD   = 5'd6;
    localparam logic [4:0] OP_LT    = 5'd7;
    localparam logic [4:0] OP_LE    = 5'd8;
    localparam logic [4:0] OP_GT    = 5'd9;
    localparam logic [4:0] OP_GE    = 5'd10;
    localparam logic [4:0] OP_INC   = 5'd11;
    localparam logic [4:0] OP_DEC   = 5'd12;
    localparam logic [4:0] OP_NOT   = 5'd13;
    localparam logic [4:0] OP_LNOT  = 5'd14;
    localparam logic [4:0] OP_SHL   = 5'd15;
    localparam logic [4:0] OP_SAR   = 5'd16;
    localparam logic [4:0] OP_SHR   = 5'd17;
    localparam logic [4:0] OP_AND   = 5'd18;
    localparam logic [4:0] OP_XOR   = 5'd19;
    localparam logic [4:0] OP_OR    = 5'd20;

    // execution class chosen by the front end
    typedef enum logic [3:0] {
        CLS_ALU = 4'b0001,
        CLS_MUL = 4'b0010,
        CLS_DIV = 4'b0100,
        CLS_MOD = 4'b1000
    } t_cls;

    // classified command held in the queue
    typedef struct packed {
        logic [4:0]    op;
        t_cls          cls;
        logic          bool_f;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
    } t_cmd;

    // finished result word
    typedef struct packed {
        logic [DW-1:0] res;
        logic          bool_f;
        logic          status;
    } t_res;

endpackage

/* hdl/ialu_if.sv */
// ----------------------------------------------------------------------------
// ialu_if
// Request and response channels of the integer ALU.
// ----------------------------------------------------------------------------
interface ialu_req_if;
    logic               valid;
    logic               ready;
    logic [4:0]         req_type;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface ialu_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] result_word;
    logic               is_boolean;
    logic               status;

    modport source (output valid, result_word, is_boolean, status, input ready);
    modport sink   (input valid, result_word, is_boolean, status, output ready);
endinterface

/* hdl/ialu_front.sv */
// ----------------------------------------------------------------------------
// ialu_front
// Decodes an incoming request word into an execution class and operands.
// ----------------------------------------------------------------------------
module ialu_front
    import ialu_pkg::*;
(
    input  logic [4:0]  i_req_type,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output t_cmd        o_cmd
);

    // classify the opcode
    always_comb begin
        o_cmd.op     = i_req_type;
        o_cmd.a      = i_operand_a[DW-1:0];
        o_cmd.b      = i_operand_b[DW-1:0];
        o_cmd.cls    = CLS_ALU;
        o_cmd.bool_f = 1'b0;
        case (i_req_type)
            OP_MUL: o_cmd.cls = CLS_MUL;
            OP_DIV: o_cmd.cls = CLS_DIV;
            OP_MOD: o_cmd.cls = CLS_MOD;
            OP_LT, OP_LE, OP_GT, OP_GE, OP_LNOT: o_cmd.bool_f = 1'b1;
            default: o_cmd.cls = CLS_ALU;
        endcase
    end

endmodule

/* hdl/ialu_queue.sv */
// ----------------------------------------------------------------------------
// ialu_queue
// Short command queue between the front end and the execution pipeline.
// ----------------------------------------------------------------------------
module ialu_queue
    import ialu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full_n,
    input  logic i_pop,
    output logic o_empty_n,
    output t_cmd o_cmd
);

    t_cmd           r_mem [QD];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt;
    logic           push_ok, pop_ok;

    assign o_full_n  = (r_cnt != QCW'(QD));
    assign o_empty_n = (r_cnt != '0);
    assign push_ok   = i_push && o_full_n;
    assign pop_ok    = i_pop && o_empty_n;
    assign o_cmd     = r_mem[r_rd];

    // store the word
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(push_ok) - QCW'(pop_ok);
        end
    end

endmodule

/* hdl/ialu_back.sv */
// ----------------------------------------------------------------------------
// ialu_back
// Execution pipeline: simple ops, split multiplier, one-bit-per-stage divider.
// ----------------------------------------------------------------------------
module ialu_back
    import ialu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    typedef struct packed {
        t_cls          cls;
        logic          bool_f;
        logic          dz;
        logic          neg_q;
        logic          neg_r;
        logic [DW-1:0] res;
        logic [DW-1:0] pll;
        logic [HW-1:0] phl;
        logic [HW-1:0] plh;
        logic [DW-1:0] mag_a;
        logic [DW-1:0] mag_b;
    } t_s0;

    typedef struct packed {
        t_cls          cls;
        logic          bool_f;
        logic          dz;
        logic          neg_q;
        logic          neg_r;
        logic [DW-1:0] quo;
        logic [DW-1:0] rem;
        logic [DW-1:0] dvs;
    } t_stg;

    // one restoring division step
    function automatic t_stg dv_step(input t_stg s);
        logic [DW:0] r2;
        logic [DW:0] df;
        t_stg        n;
        n  = s;
        r2 = {s.rem, s.quo[DW-1]};
        df = r2 - {1'b0, s.dvs};
        if (s.cls == CLS_DIV || s.cls == CLS_MOD) begin
            n.quo = {s.quo[DW-2:0], ~df[DW]};
            n.rem = df[DW] ? r2[DW-1:0] : df[DW-1:0];
        end
        return n;
    endfunction

    logic                 en;
    logic [5:0]           sh;
    logic [DW-1:0]        a, b, alu_res;
    logic [2*LW-1:0]      p_ll;
    logic [HW+LW-1:0]     p_hl, p_lh;
    logic [LW-1:0]        al, bl;
    logic [HW-1:0]        ah, bh;
    t_s0                  n_s0, r_s0;
    logic                 r_s0_v;
    t_stg                 n_s1;
    t_stg                 r_dv  [DW+1];
    logic [DW:0]          r_dv_v;
    t_res                 n_out, r_out;
    logic                 r_out_v;

    assign en        = !r_out_v || i_ready;
    assign o_cmd_pop = en;
    assign o_valid   = r_out_v;
    assign o_res     = r_out;

    assign a  = i_cmd.a;
    assign b  = i_cmd.b;
    assign sh = b[5:0];
    assign al = a[LW-1:0];
    assign ah = a[DW-1:LW];
    assign bl = b[LW-1:0];
    assign bh = b[DW-1:LW];

    // partial products of the low word of a*b
    assign p_ll = al * bl;
    assign p_hl = ah * bl;
    assign p_lh = bh * al;

    // simple operations
    always_comb begin
        case (i_cmd.op)
            OP_ADD:   alu_res = a + b;
            OP_IDENT: alu_res = a;
            OP_SUB:   alu_res = a - b;
            OP_NEG:   alu_res = '0 - a;
            OP_LT:    alu_res = DW'($signed(a) <  $signed(b));
            OP_LE:    alu_res = DW'($signed(a) <= $signed(b));
            OP_GT:    alu_res = DW'($signed(a) >  $signed(b));
            OP_GE:    alu_res = DW'($signed(a) >= $signed(b));
            OP_INC:   alu_res = a + 1'b1;
            OP_DEC:   alu_res = a - 1'b1;
            OP_NOT:   alu_res = ~a;
            OP_LNOT:  alu_res = DW'(a == '0);
            OP_SHL:   alu_res = a << sh;
            OP_SAR:   alu_res = DW'($signed(a) >>> sh);
            OP_SHR:   alu_res = a >> sh;
            OP_AND:   alu_res = a & b;
            OP_XOR:   alu_res = a ^ b;
            OP_OR:    alu_res = a | b;
            default:  alu_res = '0;
        endcase
    end

    // issue stage
    always_comb begin
        n_s0.cls    = i_cmd.cls;
        n_s0.bool_f = i_cmd.bool_f;
        n_s0.dz     = (b == '0);
        n_s0.neg_q  = a[DW-1] ^ b[DW-1];
        n_s0.neg_r  = a[DW-1];
        n_s0.res    = alu_res;
        n_s0.pll    = p_ll[DW-1:0];
        n_s0.phl    = p_hl[HW-1:0];
        n_s0.plh    = p_lh[HW-1:0];
        n_s0.mag_a  = a[DW-1] ? ('0 - a) : a;
        n_s0.mag_b  = b[DW-1] ? ('0 - b) : b;
    end

    // sum partial products, load the divider
    always_comb begin
        n_s1.cls    = r_s0.cls;
        n_s1.bool_f = r_s0.bool_f;
        n_s1.dz     = r_s0.dz;
        n_s1.neg_q  = r_s0.neg_q;
        n_s1.neg_r  = r_s0.neg_r;
        n_s1.rem    = '0;
        n_s1.dvs    = r_s0.mag_b;
        case (r_s0.cls)
            CLS_MUL: n_s1.quo = r_s0.pll + {r_s0.phl + r_s0.plh, {LW{1'b0}}};
            CLS_DIV, CLS_MOD: n_s1.quo = r_s0.mag_a;
            default: n_s1.quo = r_s0.res;
        endcase
    end

    // fix signs and flag division by zero
    always_comb begin
        n_out.bool_f = r_dv[DW].bool_f;
        n_out.status = 1'b0;
        case (r_dv[DW].cls)
            CLS_DIV: begin
                n_out.res = r_dv[DW].neg_q ? ('0 - r_dv[DW].quo) : r_dv[DW].quo;
            end
            CLS_MOD: begin
                n_out.res = r_dv[DW].neg_r ? ('0 - r_dv[DW].rem) : r_dv[DW].rem;
            end
            default: n_out.res = r_dv[DW].quo;
        endcase
        if ((r_dv[DW].cls == CLS_DIV || r_dv[DW].cls == CLS_MOD) && r_dv[DW].dz) begin
            n_out.res    = '0;
            n_out.status = 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0  <= n_s0;
            r_dv[0] <= n_s1;
            for (int k = 0; k < DW; k++) begin
                r_dv[k+1] <= dv_step(r_dv[k]);
            end
            r_out <= n_out;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_dv_v  <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s0_v  <= i_cmd_valid;
            r_dv_v  <= {r_dv_v[DW-1:0], r_s0_v};
            r_out_v <= r_dv_v[DW];
        end
    end

endmodule

/* hdl/integer_alu.sv */
// ----------------------------------------------------------------------------
// integer_alu
// 64-bit two's complement ALU with a pipelined divider.
// ----------------------------------------------------------------------------
// Requests arrive on i_req (req_type, operand_a, operand_b) and results
// leave on o_rsp (result_word, is_boolean, status), each a valid/ready
// channel; a word moves when valid and ready are both high.
// The front end classifies each word into a four-entry queue; i_req.ready
// is high while the queue has room.
// The back end is a fixed pipeline: issue, multiply sum, DW divider steps
// of one quotient bit each, and the output register. Every opcode passes
// through all of these stages, so words leave in order. Throughput is one
// word per cycle while o_rsp.ready does not stall the back end.
// When o_rsp.ready is low with a result waiting, the whole back end holds;
// the queue keeps accepting until it is full.
// Reset clears the queue and all valid bits; nothing is delivered until a
// new word is accepted.
// Division or modulo by zero gives result 0 with status 1.
// ----------------------------------------------------------------------------
module integer_alu
    import ialu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ialu_req_if.sink    i_req,
    ialu_rsp_if.source  o_rsp
);

    t_cmd front_cmd, q_cmd;
    t_res res;
    logic q_full_n, q_empty_n, pop;

    ialu_front u_front (
        .i_req_type  (i_req.req_type),
        .i_operand_a (i_req.operand_a),
        .i_operand_b (i_req.operand_b),
        .o_cmd       (front_cmd)
    );

    ialu_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_req.valid),
        .i_cmd     (front_cmd),
        .o_full_n  (q_full_n),
        .i_pop     (pop),
        .o_empty_n (q_empty_n),
        .o_cmd     (q_cmd)
    );

    ialu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_empty_n),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .o_valid     (o_rsp.valid),
        .i_ready     (o_rsp.ready),
        .o_res       (res)
    );

    // drive channel ports
    assign i_req.ready       = q_full_n;
    assign o_rsp.result_word = 64'(signed'(res.res));
    assign o_rsp.is_boolean  = res.bool_f;
    assign o_rsp.status      = res.status;

endmodule

/* hdl/ialu_chk.sv */
// ----------------------------------------------------------------------------
// ialu_chk
// Port-level checks on the integer ALU response channel.
// ----------------------------------------------------------------------------
module ialu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_result_word,
    input logic        i_is_boolean,
    input logic        i_status
);

    // hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_word))
        else $error("stalled response changed");

    // no response straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // divide by zero gives a plain zero
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_result_word == 64'd0 && !i_is_boolean)
        else $error("bad divide-by-zero response");

    // truth values are 0 or 1
    a_bool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_boolean |-> i_result_word[63:1] == 63'd0 && !i_status)
        else $error("bad boolean response");

endmodule

bind integer_alu ialu_chk u_ialu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_result_word (o_rsp.result_word),
    .i_is_boolean  (o_rsp.is_boolean),
    .i_status      (o_rsp.status)
);
